[rtl/cube_face_border_address_map_defines.svh]
// Assertion macros shared by the cube face border address map RTL.
`ifndef CUBE_FACE_BORDER_ADDRESS_MAP_DEFINES_SVH
`define CUBE_FACE_BORDER_ADDRESS_MAP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CFBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define CFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cfba_pkg.sv]
// Types, codes and the face-pair selection tables of the cube face border address map.
package cfba_pkg;

   localparam int EDGE_W  = 11;
   localparam int CHAN_W  = 3;
   localparam int FACE_W  = 3;
   localparam int SIDE_W  = 3;
   localparam int POS_W   = 10;
   localparam int COORD_W = 10;
   localparam int OFF_W   = 22;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_EDGE = 1024;

   localparam logic [EDGE_W-1:0] EDGE_RESET = 11'd258;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS  = 2'd1;

   // Border sides.
   localparam logic [SIDE_W-1:0] SIDE_NORTH      = 3'd0;
   localparam logic [SIDE_W-1:0] SIDE_SOUTH      = 3'd1;
   localparam logic [SIDE_W-1:0] SIDE_WEST       = 3'd2;
   localparam logic [SIDE_W-1:0] SIDE_EAST       = 3'd3;
   localparam logic [SIDE_W-1:0] SIDE_NORTH_WEST = 3'd4;
   localparam logic [SIDE_W-1:0] SIDE_NORTH_EAST = 3'd5;
   localparam logic [SIDE_W-1:0] SIDE_SOUTH_WEST = 3'd6;
   localparam logic [SIDE_W-1:0] SIDE_SOUTH_EAST = 3'd7;

   // Coordinate selectors: i, n-1-i, j, n-1-j, or no mapping.
   localparam logic [2:0] SEL_PI   = 3'd0;
   localparam logic [2:0] SEL_NI   = 3'd1;
   localparam logic [2:0] SEL_PJ   = 3'd2;
   localparam logic [2:0] SEL_NJ   = 3'd3;
   localparam logic [2:0] SEL_NONE = 3'd4;

   // Indexed [dest_face][src_face]; faces 6 and 7 have no mapping.
   localparam logic [2:0] ROW_SEL [0:7][0:7] = '{
      '{SEL_PI,   SEL_NONE, SEL_NJ,   SEL_PJ,   SEL_PI,   SEL_PI,   SEL_NONE, SEL_NONE},
      '{SEL_NONE, SEL_PI,   SEL_PJ,   SEL_NJ,   SEL_PI,   SEL_PI,   SEL_NONE, SEL_NONE},
      '{SEL_PJ,   SEL_NJ,   SEL_PI,   SEL_NONE, SEL_PI,   SEL_NI,   SEL_NONE, SEL_NONE},
      '{SEL_NJ,   SEL_PJ,   SEL_NONE, SEL_PI,   SEL_PI,   SEL_NI,   SEL_NONE, SEL_NONE},
      '{SEL_PI,   SEL_PI,   SEL_PI,   SEL_PI,   SEL_PI,   SEL_NONE, SEL_NONE, SEL_NONE},
      '{SEL_PI,   SEL_PI,   SEL_NI,   SEL_NI,   SEL_NONE, SEL_PI,   SEL_NONE, SEL_NONE},
      '{SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE},
      '{SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE}
   };

   localparam logic [2:0] COL_SEL [0:7][0:7] = '{
      '{SEL_PJ,   SEL_NONE, SEL_PI,   SEL_NI,   SEL_PJ,   SEL_PJ,   SEL_NONE, SEL_NONE},
      '{SEL_NONE, SEL_PJ,   SEL_NI,   SEL_PI,   SEL_PJ,   SEL_PJ,   SEL_NONE, SEL_NONE},
      '{SEL_NI,   SEL_PI,   SEL_PJ,   SEL_NONE, SEL_PJ,   SEL_NJ,   SEL_NONE, SEL_NONE},
      '{SEL_PI,   SEL_NI,   SEL_NONE, SEL_PJ,   SEL_PJ,   SEL_NJ,   SEL_NONE, SEL_NONE},
      '{SEL_PJ,   SEL_PJ,   SEL_PJ,   SEL_PJ,   SEL_PJ,   SEL_NONE, SEL_NONE, SEL_NONE},
      '{SEL_PJ,   SEL_PJ,   SEL_NJ,   SEL_NJ,   SEL_NONE, SEL_PJ,   SEL_NONE, SEL_NONE},
      '{SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE},
      '{SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE}
   };

   // Clamped configuration seen by every stage.
   typedef struct packed {
      logic [EDGE_W-1:0] n;
      logic [CHAN_W-1:0] c;
   } cfg_type;

   // Decode stage result.
   typedef struct packed {
      logic              ok;
      logic [2:0]        rs;
      logic [2:0]        cs;
      logic [EDGE_W-1:0] dr;
      logic [EDGE_W-1:0] dc;
      logic [EDGE_W-1:0] ni;
      logic [EDGE_W-1:0] nj;
   } dec_type;

   // Multiply stage result.
   typedef struct packed {
      logic              ok;
      logic [EDGE_W-1:0] dr;
      logic [EDGE_W-1:0] dc;
      logic [EDGE_W-1:0] sr;
      logic [EDGE_W-1:0] sc;
      logic [OFF_W-1:0]  dprod;
      logic [OFF_W-1:0]  sprod;
   } mul_type;

   // Final response.
   typedef struct packed {
      logic               valid_res;
      logic [COORD_W-1:0] dst_row;
      logic [COORD_W-1:0] dst_col;
      logic [COORD_W-1:0] src_row;
      logic [COORD_W-1:0] src_col;
      logic [OFF_W-1:0]   dst_offset;
      logic [OFF_W-1:0]   src_offset;
   } rsp_type;

endpackage

[rtl/cfba_decode.sv]
// Stage 1: face-pair lookup, position saturation and side decode.
module cfba_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [cfba_pkg::FACE_W-1:0]      dest_face,
   input  logic [cfba_pkg::FACE_W-1:0]      src_face,
   input  logic [cfba_pkg::SIDE_W-1:0]      side,
   input  logic [cfba_pkg::POS_W-1:0]       position,
   input  cfba_pkg::cfg_type                cfg,
   output logic                             out_valid,
   input  logic                             out_ready,
   output cfba_pkg::dec_type                out_data
);
   import cfba_pkg::*;

   logic              valid_ff;
   dec_type           data_ff;
   dec_type           data_in;
   logic [EDGE_W-1:0] last;
   logic [EDGE_W-1:0] pos_sat;
   logic [EDGE_W-1:0] pos_ext;

   assign last    = cfg.n - 11'd1;
   assign pos_ext = {1'b0, position};
   assign pos_sat = (pos_ext > last) ? last : pos_ext;

   always_comb begin
      data_in    = '0;
      data_in.rs = ROW_SEL[dest_face][src_face];
      data_in.cs = COL_SEL[dest_face][src_face];
      data_in.ok = (data_in.rs != SEL_NONE) && (data_in.cs != SEL_NONE);
      case (side)
         SIDE_NORTH: begin
            data_in.dr = '0;      data_in.dc = pos_sat;
            data_in.ni = cfg.n - 11'd2; data_in.nj = pos_sat;
         end
         SIDE_SOUTH: begin
            data_in.dr = last;    data_in.dc = pos_sat;
            data_in.ni = 11'd1;   data_in.nj = pos_sat;
         end
         SIDE_WEST: begin
            data_in.dr = pos_sat; data_in.dc = '0;
            data_in.ni = pos_sat; data_in.nj = cfg.n - 11'd2;
         end
         SIDE_EAST: begin
            data_in.dr = pos_sat; data_in.dc = last;
            data_in.ni = pos_sat; data_in.nj = 11'd1;
         end
         SIDE_NORTH_WEST: begin
            data_in.dr = '0;      data_in.dc = '0;
            data_in.ni = cfg.n - 11'd2; data_in.nj = cfg.n - 11'd2;
         end
         SIDE_NORTH_EAST: begin
            data_in.dr = '0;      data_in.dc = last;
            data_in.ni = cfg.n - 11'd2; data_in.nj = 11'd1;
         end
         SIDE_SOUTH_WEST: begin
            data_in.dr = last;    data_in.dc = '0;
            data_in.ni = 11'd1;   data_in.nj = cfg.n - 11'd2;
         end
         default: begin
            data_in.dr = last;    data_in.dc = last;
            data_in.ni = 11'd1;   data_in.nj = 11'd1;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cfba_mult.sv]
// Stage 2: source coordinate selection and row-times-edge products.
module cfba_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cfba_pkg::dec_type in_data,
   input  cfba_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output cfba_pkg::mul_type out_data
);
   import cfba_pkg::*;

   logic    valid_ff;
   mul_type data_ff;
   mul_type data_in;

   function automatic logic [EDGE_W-1:0] pick(
      logic [2:0]        sel,
      logic [EDGE_W-1:0] i,
      logic [EDGE_W-1:0] j,
      logic [EDGE_W-1:0] n
   );
      logic [EDGE_W-1:0] r;
      case (sel)
         SEL_PI:  r = i;
         SEL_NI:  r = n - 11'd1 - i;
         SEL_PJ:  r = j;
         default: r = n - 11'd1 - j;
      endcase
      return r;
   endfunction

   always_comb begin
      data_in       = '0;
      data_in.ok    = in_data.ok;
      data_in.dr    = in_data.dr;
      data_in.dc    = in_data.dc;
      data_in.sr    = pick(in_data.rs, in_data.ni, in_data.nj, cfg.n);
      data_in.sc    = pick(in_data.cs, in_data.ni, in_data.nj, cfg.n);
      data_in.dprod = OFF_W'(in_data.dr) * OFF_W'(cfg.n);
      data_in.sprod = OFF_W'(data_in.sr) * OFF_W'(cfg.n);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cfba_scale.sv]
// Stage 3: add column, scale by channel count, zero unmapped results.
module cfba_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cfba_pkg::mul_type in_data,
   input  cfba_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output cfba_pkg::rsp_type out_data
);
   import cfba_pkg::*;

   logic             valid_ff;
   rsp_type          data_ff;
   rsp_type          data_in;
   logic [OFF_W-1:0] didx;
   logic [OFF_W-1:0] sidx;

   assign didx = in_data.dprod + OFF_W'(in_data.dc);
   assign sidx = in_data.sprod + OFF_W'(in_data.sc);

   always_comb begin
      data_in = '0;
      if (in_data.ok) begin
         data_in.valid_res  = 1'b1;
         data_in.dst_row    = in_data.dr[COORD_W-1:0];
         data_in.dst_col    = in_data.dc[COORD_W-1:0];
         data_in.src_row    = in_data.sr[COORD_W-1:0];
         data_in.src_col    = in_data.sc[COORD_W-1:0];
         data_in.dst_offset = OFF_W'(didx * cfg.c);
         data_in.src_offset = OFF_W'(sidx * cfg.c);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/cube_face_border_address_map.sv]
// Requests pass the decode, multiply and scale registers to rsp_valid.
// Throughput: one request per cycle unless rsp_ready stalls the pipeline.
// Each stage holds only while its successor is full and stalled.
// The two 11x11 row-times-edge multipliers in stage 2 set the cycle time.
// Reset (synchronous, active high) empties the pipeline and loads
// edge_size = 258 and channels = 4.
module cube_face_border_address_map #(
   parameter int MAX_EDGE = cfba_pkg::DEF_MAX_EDGE
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cfba_pkg::FACE_W-1:0]        req_dest_face,
   input  logic [cfba_pkg::FACE_W-1:0]        req_src_face,
   input  logic [cfba_pkg::SIDE_W-1:0]        req_side,
   input  logic [cfba_pkg::POS_W-1:0]         req_position,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_valid_res,
   output logic [cfba_pkg::COORD_W-1:0]       rsp_dst_row,
   output logic [cfba_pkg::COORD_W-1:0]       rsp_dst_col,
   output logic [cfba_pkg::COORD_W-1:0]       rsp_src_row,
   output logic [cfba_pkg::COORD_W-1:0]       rsp_src_col,
   output logic [cfba_pkg::OFF_W-1:0]         rsp_dst_offset,
   output logic [cfba_pkg::OFF_W-1:0]         rsp_src_offset,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cfba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cfba_pkg::EDGE_W-1:0]        csr_data
);
   import cfba_pkg::*;
   `include "cube_face_border_address_map_defines.svh"

   localparam int CMP_W = 13;

   logic [EDGE_W-1:0] edge_size_ff;
   logic [CHAN_W-1:0] channels_ff;
   cfg_type           cfg;

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    mul_valid;
   logic    mul_ready;
   mul_type mul_data;
   rsp_type rsp_data;

   // Registers are always writable; every stage reads them live, so write them
   // only while the pipeline is empty.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_size_ff <= EDGE_RESET;
         channels_ff  <= CHAN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_EDGE_SIZE) begin
            edge_size_ff <= csr_data;
         end else if (csr_index == CSR_CHANNELS) begin
            channels_ff <= csr_data[CHAN_W-1:0];
         end
      end
   end

   // Clamp edge size to [3, MAX_EDGE] and channels to [1, 4].
   always_comb begin
      if (edge_size_ff < 11'd3) begin
         cfg.n = 11'd3;
      end else if ({2'b00, edge_size_ff} > CMP_W'(MAX_EDGE)) begin
         cfg.n = EDGE_W'(MAX_EDGE);
      end else begin
         cfg.n = edge_size_ff;
      end
      if (channels_ff == 3'd0) begin
         cfg.c = 3'd1;
      end else if (channels_ff > 3'd4) begin
         cfg.c = 3'd4;
      end else begin
         cfg.c = channels_ff;
      end
   end

   // Stage 1: decode the request into border and nominal interior coordinates.
   cfba_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .dest_face (req_dest_face),
      .src_face  (req_src_face),
      .side      (req_side),
      .position  (req_position),
      .cfg       (cfg),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // Stage 2: pick source coordinates and form row * edge.
   cfba_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .cfg       (cfg),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   // Stage 3: finish the offsets; this register is the response register.
   cfba_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_data   (mul_data),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_valid_res  = rsp_data.valid_res;
   assign rsp_dst_row    = rsp_data.dst_row;
   assign rsp_dst_col    = rsp_data.dst_col;
   assign rsp_src_row    = rsp_data.src_row;
   assign rsp_src_col    = rsp_data.src_col;
   assign rsp_dst_offset = rsp_data.dst_offset;
   assign rsp_src_offset = rsp_data.src_offset;

   // Back-pressure reaches the request side only when every stage is full.
   `CFBA_ASSERT_IMPLY(a_stall_full, clock, reset, !req_ready, dec_valid && mul_valid && rsp_valid && !rsp_ready, "request stalled with a stage empty")
   // Unmapped face pairs answer with all-zero fields.
   `CFBA_ASSERT_IMPLY(a_unmapped_zero, clock, reset, rsp_valid && !rsp_valid_res, rsp_dst_offset == '0 && rsp_src_offset == '0 && rsp_dst_row == '0 && rsp_src_col == '0, "unmapped response carries data")
   // With one channel the low offset bits are row times edge plus column.
   `CFBA_ASSERT_IMPLY(a_offset_floor, clock, reset, rsp_valid && rsp_valid_res && cfg.c == 3'd1, rsp_dst_offset[COORD_W-1:0] == rsp_dst_col + COORD_W'(rsp_dst_row * cfg.n), "single-channel offset mismatch")

endmodule
